[rtl/core/itoa_pkg.sv]
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared types and constants of the integer to ASCII formatter.
// ----------------------------------------------------------------------------
package itoa_pkg;

    localparam int FLAG_ZEROPAD = 0;
    localparam int FLAG_SIGNED  = 1;
    localparam int FLAG_PLUS    = 2;
    localparam int FLAG_SPACE   = 3;
    localparam int FLAG_LEFT    = 4;
    localparam int FLAG_PREFIX  = 5;
    localparam int FLAG_UPPER   = 6;

    localparam logic [5:0] MIN_RADIX   = 6'd2;
    localparam logic [5:0] MAX_RADIX   = 6'd36;
    localparam logic [5:0] OCT_RADIX   = 6'd8;
    localparam logic [5:0] HEX_RADIX   = 6'd16;
    localparam logic [5:0] PFX_X_DIGIT = 6'd33;

    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_PLUS    = 8'h2b;
    localparam logic [7:0] CH_MINUS   = 8'h2d;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7a;

    typedef struct packed {
        logic [5:0]        radix;
        logic signed [7:0] size;
        logic signed [6:0] prec;
        logic [7:0]        sign_ch;
        logic              has_sign;
        logic [1:0]        pfx_len;
        logic              upper;
        logic              zeropad;
        logic              left;
    } t_desc;

endpackage

[rtl/core/itoa_front.sv]
// ----------------------------------------------------------------------------
// itoa_front
// Accepts format requests, resolves sign, prefix, width and precision, and
// hands a descriptor with the magnitude to the queue. Bad radix is dropped.
// ----------------------------------------------------------------------------
module itoa_front #(
    parameter int VALUE_BITS = 32,
    parameter int MAX_FIELD  = 60
) (
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [VALUE_BITS-1:0]   i_value,
    input  logic [5:0]              i_radix,
    input  logic signed [6:0]       i_field_width,
    input  logic signed [6:0]       i_min_digits,
    input  logic [6:0]              i_flag_bits,
    input  logic                    i_q_full,
    output logic                    o_push,
    output itoa_pkg::t_desc         o_desc,
    output logic [VALUE_BITS-1:0]   o_mag
);
    import itoa_pkg::*;

    function automatic logic signed [6:0] lim_field(input logic [6:0] raw);
        logic signed [6:0] res;
        if (raw[6]) begin
            res = '1;
        end else if (raw[5:0] > 6'(MAX_FIELD)) begin
            res = {1'b0, 6'(MAX_FIELD)};
        end else begin
            res = raw;
        end
        return res;
    endfunction

    logic              w_base_ok;
    logic              w_neg;
    logic              w_has_sign;
    logic [1:0]        w_pfx_len;
    logic signed [6:0] w_fw;

    assign w_base_ok  = (i_radix >= MIN_RADIX) && (i_radix <= MAX_RADIX);
    assign w_neg      = i_flag_bits[FLAG_SIGNED] && i_value[VALUE_BITS-1];
    assign w_has_sign = i_flag_bits[FLAG_SIGNED] &&
                        (w_neg || i_flag_bits[FLAG_PLUS] || i_flag_bits[FLAG_SPACE]);
    assign w_fw       = lim_field(i_field_width);

    always_comb begin
        w_pfx_len = 2'd0;
        if (i_flag_bits[FLAG_PREFIX]) begin
            if (i_radix == HEX_RADIX) begin
                w_pfx_len = 2'd2;
            end else if (i_radix == OCT_RADIX) begin
                w_pfx_len = 2'd1;
            end
        end
    end

    always_comb begin
        o_desc.radix    = i_radix;
        o_desc.size     = 8'(w_fw) - 8'(w_has_sign) - 8'(w_pfx_len);
        o_desc.prec     = lim_field(i_min_digits);
        o_desc.sign_ch  = w_neg ? CH_MINUS : (i_flag_bits[FLAG_PLUS] ? CH_PLUS : CH_SPACE);
        o_desc.has_sign = w_has_sign;
        o_desc.pfx_len  = w_pfx_len;
        o_desc.upper    = i_flag_bits[FLAG_UPPER];
        o_desc.zeropad  = i_flag_bits[FLAG_ZEROPAD] && !i_flag_bits[FLAG_LEFT];
        o_desc.left     = i_flag_bits[FLAG_LEFT];
    end

    assign o_mag   = w_neg ? (~i_value + 1'b1) : i_value;
    assign o_stall = i_q_full;
    assign o_push  = i_valid && !i_q_full && w_base_ok;

endmodule

[rtl/core/itoa_queue.sv]
// ----------------------------------------------------------------------------
// itoa_queue
// Small register FIFO between the request front end and the formatter.
// ----------------------------------------------------------------------------
module itoa_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty,
    output logic             o_full
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr;
    logic [PW-1:0]    r_rd;
    logic [CW-1:0]    r_count;
    logic             w_push;
    logic             w_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CW'(DEPTH));
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

[rtl/core/itoa_back.sv]
// ----------------------------------------------------------------------------
// itoa_back
// Extracts digits by restoring division, eight quotient bits per cycle,
// then streams the formatted text one character per transfer.
// ----------------------------------------------------------------------------
module itoa_back #(
    parameter int VALUE_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_valid,
    output logic                  o_q_pop,
    input  itoa_pkg::t_desc       i_desc,
    input  logic [VALUE_BITS-1:0] i_mag,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [7:0]            o_out_char,
    output logic                  o_last
);
    import itoa_pkg::*;

    localparam int DIV_STEPS = 8;
    localparam int DIV_W     = ((VALUE_BITS + DIV_STEPS - 1) / DIV_STEPS) * DIV_STEPS;
    localparam int DIV_CYC   = DIV_W / DIV_STEPS;
    localparam int CYC_W     = (DIV_CYC > 1) ? $clog2(DIV_CYC) : 1;
    localparam int ND_W      = $clog2(VALUE_BITS + 1);

    typedef enum logic [1:0] {S_IDLE, S_DIV, S_SETUP, S_EMIT} t_state;

    function automatic logic [7:0] digit_char(input logic [5:0] d, input logic up);
        logic [7:0] ch;
        if (d < 6'd10) begin
            ch = CH_ZERO + {2'b00, d};
        end else begin
            ch = (up ? CH_UPPER_A : CH_LOWER_A) + {2'b00, d} - 8'd10;
        end
        return ch;
    endfunction

    t_state            r_state, n_state;
    logic              r_ovalid, n_ovalid;
    logic [7:0]        r_char, n_char;
    logic              r_last, n_last;
    logic [DIV_W-1:0]  r_work, n_work;
    logic [5:0]        r_rem, n_rem;
    logic [CYC_W-1:0]  r_cyc, n_cyc;
    logic [ND_W-1:0]   r_nd, n_nd;
    logic [5:0]        r_base, n_base;
    logic signed [7:0] r_size, n_size;
    logic signed [6:0] r_prec, n_prec;
    logic [7:0]        r_sign_ch, n_sign_ch;
    logic              r_sign, n_sign;
    logic [1:0]        r_pfx, n_pfx;
    logic              r_hex, n_hex;
    logic              r_upper, n_upper;
    logic              r_zeropad, n_zeropad;
    logic              r_left, n_left;
    logic [5:0]        r_lead, n_lead;
    logic [5:0]        r_zero, n_zero;
    logic [5:0]        r_trail, n_trail;
    logic [5:0]        r_total, n_total;
    logic [5:0]        r_stack [VALUE_BITS];
    logic              w_push;
    logic              w_pop;
    logic [6:0]        v_rem;
    logic [DIV_W-1:0]  v_work;
    logic              v_qb;
    logic signed [7:0] v_nd8;
    logic signed [7:0] v_prec8;
    logic signed [7:0] v_prec_eff;
    logic signed [7:0] v_pad;
    logic signed [7:0] v_pz;
    logic [5:0]        v_padcnt;
    logic              w_free;

    assign w_free = !r_ovalid || !i_stall;

    always_comb begin
        v_work = r_work;
        v_rem  = {1'b0, r_rem};
        for (int k = 0; k < DIV_STEPS; k++) begin
            v_rem = {v_rem[5:0], v_work[DIV_W-1]};
            v_qb  = (v_rem >= {1'b0, r_base});
            if (v_qb) begin
                v_rem = v_rem - {1'b0, r_base};
            end
            v_work = {v_work[DIV_W-2:0], v_qb};
        end
    end

    always_comb begin
        v_nd8      = 8'(r_nd);
        v_prec8    = 8'(r_prec);
        v_prec_eff = (v_prec8 > v_nd8) ? v_prec8 : v_nd8;
        v_pad      = r_size - v_prec_eff;
        v_pz       = v_prec_eff - v_nd8;
        v_padcnt   = (v_pad > 8'sd0) ? v_pad[5:0] : 6'd0;
    end

    always_comb begin
        n_state   = r_state;
        n_ovalid  = r_ovalid && i_stall;
        n_char    = r_char;
        n_last    = r_last;
        n_work    = r_work;
        n_rem     = r_rem;
        n_cyc     = r_cyc;
        n_nd      = r_nd;
        n_base    = r_base;
        n_size    = r_size;
        n_prec    = r_prec;
        n_sign_ch = r_sign_ch;
        n_sign    = r_sign;
        n_pfx     = r_pfx;
        n_hex     = r_hex;
        n_upper   = r_upper;
        n_zeropad = r_zeropad;
        n_left    = r_left;
        n_lead    = r_lead;
        n_zero    = r_zero;
        n_trail   = r_trail;
        n_total   = r_total;
        o_q_pop   = 1'b0;
        w_push    = 1'b0;
        w_pop     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop   = 1'b1;
                    n_state   = S_DIV;
                    n_work    = DIV_W'(i_mag);
                    n_rem     = '0;
                    n_cyc     = '0;
                    n_nd      = '0;
                    n_base    = i_desc.radix;
                    n_size    = i_desc.size;
                    n_prec    = i_desc.prec;
                    n_sign_ch = i_desc.sign_ch;
                    n_sign    = i_desc.has_sign;
                    n_pfx     = i_desc.pfx_len;
                    n_hex     = (i_desc.pfx_len == 2'd2);
                    n_upper   = i_desc.upper;
                    n_zeropad = i_desc.zeropad;
                    n_left    = i_desc.left;
                end
            end
            S_DIV: begin
                n_work = v_work;
                n_rem  = v_rem[5:0];
                n_cyc  = r_cyc + 1'b1;
                if (r_cyc == CYC_W'(DIV_CYC - 1)) begin
                    w_push = 1'b1;
                    n_cyc  = '0;
                    n_rem  = '0;
                    n_nd   = r_nd + 1'b1;
                    if (v_work == '0) begin
                        n_state = S_SETUP;
                    end
                end
            end
            S_SETUP: begin
                n_lead  = (!r_zeropad && !r_left) ? v_padcnt : 6'd0;
                n_trail = r_left ? v_padcnt : 6'd0;
                n_zero  = (r_zeropad ? v_padcnt : 6'd0) + v_pz[5:0];
                n_total = n_lead + 6'(r_sign) + 6'(r_pfx) + n_zero + 6'(r_nd) + n_trail;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_free) begin
                    n_ovalid = 1'b1;
                    n_last   = (r_total == 6'd1);
                    n_total  = r_total - 1'b1;
                    if (r_total == 6'd1) begin
                        n_state = S_IDLE;
                    end
                    priority if (r_lead != '0) begin
                        n_char = CH_SPACE;
                        n_lead = r_lead - 1'b1;
                    end else if (r_sign) begin
                        n_char = r_sign_ch;
                        n_sign = 1'b0;
                    end else if (r_pfx != '0) begin
                        n_char = (r_pfx == 2'd1 && r_hex) ? digit_char(PFX_X_DIGIT, r_upper)
                                                          : CH_ZERO;
                        n_pfx  = r_pfx - 1'b1;
                    end else if (r_zero != '0) begin
                        n_char = CH_ZERO;
                        n_zero = r_zero - 1'b1;
                    end else if (r_nd != '0) begin
                        n_char = digit_char(r_stack[0], r_upper);
                        n_nd   = r_nd - 1'b1;
                        w_pop  = 1'b1;
                    end else begin
                        n_char  = CH_SPACE;
                        n_trail = r_trail - 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
        r_char    <= n_char;
        r_last    <= n_last;
        r_work    <= n_work;
        r_rem     <= n_rem;
        r_cyc     <= n_cyc;
        r_nd      <= n_nd;
        r_base    <= n_base;
        r_size    <= n_size;
        r_prec    <= n_prec;
        r_sign_ch <= n_sign_ch;
        r_sign    <= n_sign;
        r_pfx     <= n_pfx;
        r_hex     <= n_hex;
        r_upper   <= n_upper;
        r_zeropad <= n_zeropad;
        r_left    <= n_left;
        r_lead    <= n_lead;
        r_zero    <= n_zero;
        r_trail   <= n_trail;
        r_total   <= n_total;
    end

    // push new digit on top, pop toward the top
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_stack[0] <= v_rem[5:0];
            for (int i = 1; i < VALUE_BITS; i++) begin
                r_stack[i] <= r_stack[i-1];
            end
        end else if (w_pop) begin
            for (int i = 0; i < VALUE_BITS - 1; i++) begin
                r_stack[i] <= r_stack[i+1];
            end
        end
    end

    assign o_valid    = r_ovalid;
    assign o_out_char = r_char;
    assign o_last     = r_last;

endmodule

[rtl/core/integer_to_ascii_formatter.sv]
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter
// printf-style integer to text conversion, one ASCII character per transfer.
// ----------------------------------------------------------------------------
// Each request is formatted into 1 to 63 characters, the final one flagged by
// o_last; a radix outside 2..36 produces no output. Requests pass through a
// two-entry queue, so up to two can be taken while the formatter is busy.
// Digits come from a restoring divider that resolves 8 quotient bits per
// cycle. An item occupies the formatter for digit extraction, then a setup
// step, then the emission of its characters, which the receiver can hold
// back with i_stall.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter #(
    parameter int VALUE_BITS = 32,
    parameter int MAX_FIELD  = 60
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [VALUE_BITS-1:0] i_value,
    input  logic [5:0]            i_radix,
    input  logic signed [6:0]     i_field_width,
    input  logic signed [6:0]     i_min_digits,
    input  logic [6:0]            i_flag_bits,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [7:0]            o_out_char,
    output logic                  o_last
);
    import itoa_pkg::*;

    localparam int DESC_W = $bits(t_desc);
    localparam int QW     = VALUE_BITS + DESC_W;

    t_desc                 w_front_desc;
    logic [VALUE_BITS-1:0] w_front_mag;
    logic                  w_push;
    logic                  w_pop;
    logic                  w_q_empty;
    logic                  w_q_full;
    logic [QW-1:0]         w_q_dout;

    itoa_front #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_FIELD  (MAX_FIELD)
    ) u_front (
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_value       (i_value),
        .i_radix       (i_radix),
        .i_field_width (i_field_width),
        .i_min_digits  (i_min_digits),
        .i_flag_bits   (i_flag_bits),
        .i_q_full      (w_q_full),
        .o_push        (w_push),
        .o_desc        (w_front_desc),
        .o_mag         (w_front_mag)
    );

    itoa_queue #(
        .WIDTH (QW),
        .DEPTH (2)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  ({w_front_mag, w_front_desc}),
        .i_pop   (w_pop),
        .o_data  (w_q_dout),
        .o_empty (w_q_empty),
        .o_full  (w_q_full)
    );

    itoa_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (!w_q_empty),
        .o_q_pop    (w_pop),
        .i_desc     (t_desc'(w_q_dout[DESC_W-1:0])),
        .i_mag      (w_q_dout[QW-1:DESC_W]),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_out_char (o_out_char),
        .o_last     (o_last)
    );

    a_bad_radix_dropped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && (i_radix < MIN_RADIX || i_radix > MAX_RADIX)) |-> !w_push)
        else $error("request with bad radix entered the queue");

    a_good_radix_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_radix >= MIN_RADIX && i_radix <= MAX_RADIX)
        |=> !w_q_empty)
        else $error("accepted request missing from queue");

    a_char_printable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_out_char >= CH_SPACE && o_out_char <= CH_LOWER_Z))
        else $error("output character out of range");

endmodule

[sim/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the printf-style integer to ASCII formatter.
// ----------------------------------------------------------------------------
// A directed set covers field extremes, sign and prefix rules, saturation,
// absent width/precision and invalid radixes; random requests follow. Every
// accepted request is formatted by a behavioral model into the expected
// character stream, and each character transfer is checked against it.
// Sender bursts/gaps, receiver stall patterns, one long receiver hold and
// drain pauses exercise the handshakes.
// ----------------------------------------------------------------------------
module tb;
    import itoa_pkg::*;

    localparam int VALUE_BITS = 32;
    localparam int MAX_FIELD  = 60;
    localparam int IDLE_LIMIT = 5000;
    localparam int LONG_HOLD  = 1500;
    localparam int TAIL_CYCLES = 400;
    localparam int RANDOM_REQS = 250;

    localparam logic [6:0] F_ZP = 7'(1 << FLAG_ZEROPAD);
    localparam logic [6:0] F_SG = 7'(1 << FLAG_SIGNED);
    localparam logic [6:0] F_PL = 7'(1 << FLAG_PLUS);
    localparam logic [6:0] F_SP = 7'(1 << FLAG_SPACE);
    localparam logic [6:0] F_LF = 7'(1 << FLAG_LEFT);
    localparam logic [6:0] F_PX = 7'(1 << FLAG_PREFIX);
    localparam logic [6:0] F_UP = 7'(1 << FLAG_UPPER);

    typedef struct {
        logic [31:0] value;
        logic [5:0]  radix;
        logic [6:0]  fw;
        logic [6:0]  md;
        logic [6:0]  flags;
        bit          drain_first;
    } text_req_t;

    typedef struct {
        logic [7:0] ch;
        logic       last;
    } text_char_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic [VALUE_BITS-1:0] i_value = '0;
    logic [5:0]            i_radix = '0;
    logic signed [6:0]     i_field_width = '0;
    logic signed [6:0]     i_min_digits = '0;
    logic [6:0]            i_flag_bits = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic [7:0]            o_out_char;
    logic                  o_last;

    text_req_t  pending_reqs[$];
    text_char_t expected_chars[$];
    text_req_t  cur_req;

    int reqs_taken = 0;
    int silent_reqs = 0;
    int chars_checked = 0;
    int mismatches = 0;
    int burst_left = 1;
    int gap_left = 0;
    int idle_cycles = 0;

    integer_to_ascii_formatter #(
        .VALUE_BITS(VALUE_BITS),
        .MAX_FIELD (MAX_FIELD)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_value      (i_value),
        .i_radix      (i_radix),
        .i_field_width(i_field_width),
        .i_min_digits (i_min_digits),
        .i_flag_bits  (i_flag_bits),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_char   (o_out_char),
        .o_last       (o_last)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int field_limit(input logic [6:0] raw);
        if (raw[6]) return -1;
        if (int'(raw[5:0]) > MAX_FIELD) return MAX_FIELD;
        return int'(raw[5:0]);
    endfunction

    function automatic logic [7:0] digit_char(input int d, input bit upper);
        if (d < 10) return CH_ZERO + 8'(d);
        return (upper ? CH_UPPER_A : CH_LOWER_A) + 8'(d - 10);
    endfunction

    // Format one request into expected_chars; return the character count.
    function automatic int format_text(input text_req_t r);
        logic [31:0] mag;
        logic [7:0]  sign_ch;
        logic [7:0]  digs[40];
        logic [7:0]  line[$];
        text_char_t  c;
        bit          upper, left, zeropad, prefix, has_sign;
        int          size, prec, nd, fill;
        upper   = r.flags[FLAG_UPPER];
        left    = r.flags[FLAG_LEFT];
        zeropad = r.flags[FLAG_ZEROPAD] && !left;
        prefix  = r.flags[FLAG_PREFIX];
        if (r.radix < MIN_RADIX || r.radix > MAX_RADIX) return 0;
        size = field_limit(r.fw);
        prec = field_limit(r.md);
        mag = r.value;
        has_sign = 1'b0;
        sign_ch = CH_SPACE;
        if (r.flags[FLAG_SIGNED]) begin
            if (mag[VALUE_BITS-1]) begin
                has_sign = 1'b1;
                sign_ch = CH_MINUS;
                mag = -mag;
            end else if (r.flags[FLAG_PLUS]) begin
                has_sign = 1'b1;
                sign_ch = CH_PLUS;
            end else if (r.flags[FLAG_SPACE]) begin
                has_sign = 1'b1;
            end
            if (has_sign) size--;
        end
        if (prefix && r.radix == HEX_RADIX) size -= 2;
        else if (prefix && r.radix == OCT_RADIX) size -= 1;
        nd = 0;
        do begin
            digs[nd] = digit_char(int'(mag % 32'(r.radix)), upper);
            nd++;
            mag = mag / 32'(r.radix);
        end while (mag != 0);
        if (nd > prec) prec = nd;
        size -= prec;
        fill = (size > 0) ? size : 0;
        if (!zeropad && !left) repeat (fill) line.push_back(CH_SPACE);
        if (has_sign) line.push_back(sign_ch);
        if (prefix && r.radix == OCT_RADIX) begin
            line.push_back(CH_ZERO);
        end else if (prefix && r.radix == HEX_RADIX) begin
            line.push_back(CH_ZERO);
            line.push_back(digit_char(int'(PFX_X_DIGIT), upper));
        end
        if (zeropad) repeat (fill) line.push_back(CH_ZERO);
        repeat (prec - nd) line.push_back(CH_ZERO);
        for (int i = nd - 1; i >= 0; i--) line.push_back(digs[i]);
        if (left) repeat (fill) line.push_back(CH_SPACE);
        foreach (line[i]) begin
            c.ch = line[i];
            c.last = (i == line.size() - 1);
            expected_chars.push_back(c);
        end
        return line.size();
    endfunction

    task automatic add_req(input logic [31:0] v, input int rdx, input int fw, input int md,
                           input logic [6:0] fl, input bit drain = 1'b0);
        text_req_t r;
        r.value = v;
        r.radix = rdx[5:0];
        r.fw = fw[6:0];
        r.md = md[6:0];
        r.flags = fl;
        r.drain_first = drain;
        pending_reqs.push_back(r);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 40);
            1: return 32'hFFFF_FFFF - $urandom_range(0, 40);
            2: return 32'h8000_0000 + $urandom_range(0, 40) - 20;
            default: return $urandom;
        endcase
    endfunction

    function automatic int pick_radix();
        case ($urandom_range(0, 9))
            0: return $urandom_range(0, 63);
            1: return OCT_RADIX;
            2, 3: return HEX_RADIX;
            4: return 10;
            default: return $urandom_range(2, 36);
        endcase
    endfunction

    function automatic int pick_field(input int typical);
        case ($urandom_range(0, 4))
            0: return -1;
            1, 2: return $urandom_range(0, typical);
            3: return $urandom_range(0, 127);
            default: return $urandom_range(typical, 63);
        endcase
    endfunction

    // Sender: bursts of transfers separated by random gaps.
    always @(posedge i_clk) begin
        bit took;
        bit offer;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            took = i_valid && !o_stall;
            if (took) begin
                if (format_text(cur_req) == 0) silent_reqs++;
                reqs_taken++;
            end
            offer = i_valid && !took;
            if (!offer) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_reqs.size() > 0 &&
                             !(pending_reqs[0].drain_first && expected_chars.size() != 0)) begin
                    cur_req = pending_reqs.pop_front();
                    i_value <= cur_req.value;
                    i_radix <= cur_req.radix;
                    i_field_width <= cur_req.fw;
                    i_min_digits <= cur_req.md;
                    i_flag_bits <= cur_req.flags;
                    offer = 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
                    end
                end
            end
            i_valid <= offer;
        end
    end

    // Receiver: changing stall patterns plus one long hold.
    always @(posedge i_clk) begin
        int  pat_mode;
        int  pat_left;
        int  hold_left;
        int  rx_seen;
        bit  hold_done;
        bit  nxt_stall;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            pat_mode = 0;
            pat_left = 0;
            hold_left = 0;
            rx_seen = 0;
            hold_done = 1'b0;
        end else begin
            if (o_valid && !i_stall) rx_seen++;
            if (!hold_done && rx_seen >= 600) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (pat_left == 0) begin
                pat_mode = $urandom_range(0, 3);
                pat_left = $urandom_range(10, 200);
            end
            pat_left--;
            case (pat_mode)
                0: nxt_stall = 1'b0;
                1: nxt_stall = ($urandom_range(0, 3) == 0);
                2: nxt_stall = ($urandom_range(0, 3) != 0);
                default: nxt_stall = ~i_stall;
            endcase
            if (hold_left > 0) begin
                hold_left--;
                nxt_stall = 1'b1;
            end
            i_stall <= nxt_stall;
        end
    end

    always @(posedge i_clk) begin
        text_char_t want;
        if (i_rst_n && o_valid && !i_stall) begin
            chars_checked++;
            if (expected_chars.size() == 0) begin
                $error("unexpected transfer: out_char %h last %b", o_out_char, o_last);
                mismatches++;
            end else begin
                want = expected_chars.pop_front();
                if (o_out_char !== want.ch) begin
                    $error("out_char: expected %h, actual %h", want.ch, o_out_char);
                    mismatches++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %b, actual %b", want.last, o_last);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial begin
        add_req(32'd0, 10, -1, -1, '0);
        add_req(32'd0, 10, -1, 0, '0);
        add_req(32'd0, OCT_RADIX, -1, -1, F_PX);
        add_req(32'd0, HEX_RADIX, 5, -1, F_PX | F_ZP);
        add_req(32'hFFFF_FFFF, HEX_RADIX, 63, -1, F_PX | F_UP);
        add_req(32'hFFFF_FFFF, 2, -1, -1, '0);
        add_req(32'h8000_0000, 10, -1, -1, F_SG);
        add_req(32'h8000_0000, 2, 60, -1, F_SG | F_ZP);
        add_req(32'h8000_0000, HEX_RADIX, -1, 63, F_SG | F_PX | F_UP);
        add_req(32'd123, 10, 8, -1, F_SG | F_PL);
        add_req(32'd123, 10, 8, -1, F_SG | F_SP);
        add_req(32'd123, 10, 8, -1, F_SG | F_PL | F_SP);
        add_req(32'd123, 10, 8, -1, F_PL | F_SP);
        add_req(-32'sd123, 10, 12, 5, F_SG | F_ZP | F_LF);
        add_req(-32'sd5, 10, 12, 5, F_SG | F_ZP);
        add_req(32'd255, OCT_RADIX, 10, -1, F_PX | F_LF);
        add_req(32'd1295, 36, -1, -1, '0);
        add_req(32'd1295, 36, -1, -1, F_UP);
        add_req(32'd7, 0, -1, -1, '0);
        add_req(32'd7, 1, 10, -1, F_SG);
        add_req(32'd7, 37, -1, -1, '0);
        add_req(32'd7, 63, 20, 20, 7'h7f);
        add_req(32'd42, 3, -64, -64, F_SG | F_SP);
        add_req(32'd42, 10, 61, 62, F_ZP);
        add_req(32'd0, 7, 0, 0, '0, 1'b1);
        for (int n = 0; n < RANDOM_REQS; n++) begin
            add_req(pick_value(), pick_radix(), pick_field(20), pick_field(12),
                    7'($urandom), (n == 150 || n == 220));
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || i_valid) @(posedge i_clk);
        while (expected_chars.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Covered %0d requests (%0d with invalid radix) and %0d character transfers,",
                 reqs_taken, silent_reqs, chars_checked);
        $display("with sender gaps, receiver stalls, a long hold and drain pauses.");
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
